// ----- rtl/core/flow_cache_meter_defines.svh -----
// Assertion helpers for the flow cache meter.
`ifndef FLOW_CACHE_METER_DEFINES_SVH
`define FLOW_CACHE_METER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define FCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, once seen, must be followed by a consequence in the next cycle.
`define FCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/fcm_pkg.sv -----
package fcm_pkg;

    localparam int FLOW_ENTRIES = 32;
    localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam logic [15:0] DEFAULT_INTERVAL = 16'd30;

    localparam logic [1:0] REG_INTERVAL   = 2'd0;
    localparam logic [1:0] REG_START_TIME = 2'd1;

    typedef struct packed {
        logic        ipv6;
        logic        tcp;
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [63:0] dst_high;
        logic [63:0] dst_low;
        logic [15:0] sport;
        logic [15:0] dport;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic [63:0] packets;
        logic [63:0] bytes;
        logic [31:0] first;
        logic [31:0] last;
    } entry_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             shift;
        logic             update;
        logic             append;
        logic [CNT_W-1:0] count;
    } ctrl_t;

endpackage

// ----- rtl/core/fcm_cell.sv -----
module fcm_cell
(
    input  logic                     clk,
    input  logic [fcm_pkg::CNT_W-1:0] position,
    input  fcm_pkg::ctrl_t           ctrl,
    input  fcm_pkg::key_t            key,
    input  logic [15:0]              plen,
    input  logic [31:0]              now,
    input  fcm_pkg::entry_t          neighbour,
    output fcm_pkg::entry_t          entry,
    output logic                     hit,
    output logic                     live
);

    fcm_pkg::entry_t entry_reg;
    fcm_pkg::entry_t entry_next;
    logic            used;
    logic [63:0]     packets_inc;

    // The cell holds a flow only while its place lies below the count.
    assign used        = position < ctrl.count;
    assign hit         = used && (entry_reg.key == key);
    assign live        = used && (entry_reg.packets != 64'd0);
    assign entry       = entry_reg;
    assign packets_inc = entry_reg.packets + 64'd1;

    // Shift towards the head on export, load a new flow, or count a packet.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = neighbour;
        end
        else if (ctrl.append && (position == ctrl.count))
        begin
            entry_next.key     = key;
            entry_next.packets = 64'd1;
            entry_next.bytes   = {48'd0, plen};
            entry_next.first   = now;
            entry_next.last    = now;
        end
        else if (ctrl.update && hit)
        begin
            entry_next.packets = packets_inc;
            entry_next.bytes   = entry_reg.bytes + {48'd0, plen};
            if (packets_inc == 64'd1)
            begin
                entry_next.first = now;
            end
            entry_next.last = now;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/core/flow_cache_meter.sv -----
// Flow cache with periodic export. Each accepted word is one parsed packet
// header; the idle state accepts it and runs the export check, and the update
// state does the parallel key compare in the row of cells and the counter
// update. When the export interval has elapsed, the stored flows are first
// shifted out of the row one cell per cycle while the output side does not
// stall a live head, and the packet is then handled in the update state.
// Records with a zero packet count are skipped, the final record of a run
// carries tlast, and the table is emptied.
`include "flow_cache_meter_defines.svh"

module flow_cache_meter
(
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata from bit 0: src_addr_high, src_addr_low, dst_addr_high,
    // dst_addr_low, source port, destination port, packet_length,
    // arrival_seconds
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [335:0] s_tdata,
    // s_tuser from bit 0: frame type, ip_protocol
    input  logic [23:0]  s_tuser,
    // m_tdata from bit 0: out_src_high, out_src_low, out_dst_high, out_dst_low,
    // flow source port, flow destination port, packets_seen, bytes_seen,
    // first_time, last_time
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [479:0] m_tdata,
    // m_tuser from bit 0: flow_kind
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int N = fcm_pkg::FLOW_ENTRIES;
    localparam int W = fcm_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPORT = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0]   state_reg;
    logic [1:0]   state_next;
    logic [15:0]  interval_reg;
    logic [31:0]  last_export_reg;
    logic [W-1:0] flows_used_reg;
    logic [W-1:0] rem_reg;

    fcm_pkg::key_t key_reg;
    logic [15:0]   plen_reg;
    logic [31:0]   now_reg;
    logic          keep_reg;

    logic          out_valid_reg;
    logic          out_last_reg;
    fcm_pkg::entry_t out_reg;

    fcm_pkg::ctrl_t  ctrl;
    fcm_pkg::entry_t cell_entry [N];
    logic [N-1:0]    hit;
    logic [N-1:0]    live;

    logic        accept;
    logic        out_free;
    logic        do_export;
    logic        v6_in;
    logic        keep_in;
    logic [31:0] age;
    logic        step;
    logic        append;
    fcm_pkg::key_t key_in;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // Export check on the arriving word.
    assign age       = s_tdata[335:304] - last_export_reg;
    assign do_export = (s_tdata[335:304] >= last_export_reg) && (age >= {16'd0, interval_reg});

    // Filter and key formation; IPv4 keeps only the low 32 address bits.
    assign v6_in   = (s_tuser[15:0] == fcm_pkg::ETH_IPV6);
    assign keep_in = ((s_tuser[15:0] == fcm_pkg::ETH_IPV4) || v6_in)
                     && ((s_tuser[23:16] == fcm_pkg::PROTO_TCP)
                     || (s_tuser[23:16] == fcm_pkg::PROTO_UDP));

    always_comb
    begin
        key_in.ipv6     = v6_in;
        key_in.tcp      = (s_tuser[23:16] == fcm_pkg::PROTO_TCP);
        key_in.src_high = v6_in ? s_tdata[63:0] : 64'd0;
        key_in.src_low  = v6_in ? s_tdata[127:64] : {32'd0, s_tdata[95:64]};
        key_in.dst_high = v6_in ? s_tdata[191:128] : 64'd0;
        key_in.dst_low  = v6_in ? s_tdata[255:192] : {32'd0, s_tdata[223:192]};
        key_in.sport    = s_tdata[271:256];
        key_in.dport    = s_tdata[287:272];
    end

    // An export step moves the row by one cell unless a live head must wait.
    assign step   = (state_reg == ST_EXPORT) && (rem_reg != '0) && (!live[0] || out_free);
    assign append = (state_reg == ST_UPDATE) && keep_reg && (hit == '0)
                    && (flows_used_reg < W'(N));

    always_comb
    begin
        ctrl.shift  = step;
        ctrl.update = (state_reg == ST_UPDATE) && keep_reg;
        ctrl.append = append;
        ctrl.count  = (state_reg == ST_EXPORT) ? rem_reg : flows_used_reg;
    end

    // Row of flow cells; each one but the last takes its right neighbour's entry on a shift, the last keeps its own.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        fcm_cell u_cell
        (
            .clk       (clk),
            .position  (W'(i)),
            .ctrl      (ctrl),
            .key       (key_reg),
            .plen      (plen_reg),
            .now       (now_reg),
            .neighbour (cell_entry[(i + 1 < N) ? i + 1 : i]),
            .entry     (cell_entry[i]),
            .hit       (hit[i]),
            .live      (live[i])
        );
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = do_export ? ST_EXPORT : ST_UPDATE;
                end
            end
            ST_EXPORT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            interval_reg    <= fcm_pkg::DEFAULT_INTERVAL;
            last_export_reg <= 32'd0;
            flows_used_reg  <= '0;
            rem_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && (cfg_index == fcm_pkg::REG_INTERVAL))
            begin
                interval_reg <= cfg_data[15:0];
            end
            if (cfg_we && (cfg_index == fcm_pkg::REG_START_TIME))
            begin
                last_export_reg <= cfg_data;
            end
            else if (accept && do_export)
            begin
                last_export_reg <= s_tdata[335:304];
            end
            if (accept)
            begin
                rem_reg <= flows_used_reg;
            end
            else if (step)
            begin
                rem_reg <= rem_reg - W'(1);
            end
            if ((state_reg == ST_EXPORT) && (rem_reg == '0))
            begin
                flows_used_reg <= '0;
            end
            else if (append)
            begin
                flows_used_reg <= flows_used_reg + W'(1);
            end
            if (step && live[0])
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Packet and record payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= key_in;
            plen_reg <= s_tdata[303:288];
            now_reg  <= s_tdata[335:304];
            keep_reg <= keep_in;
        end
        if (step && live[0])
        begin
            out_reg      <= cell_entry[0];
            out_last_reg <= ((live >> 1) == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_reg.key.ipv6, out_reg.key.tcp};
    assign m_tdata  = {out_reg.last, out_reg.first, out_reg.bytes, out_reg.packets,
                       out_reg.key.dport, out_reg.key.sport,
                       out_reg.key.dst_low, out_reg.key.dst_high,
                       out_reg.key.src_low, out_reg.key.src_high};

    `FCM_ASSERT(a_single_hit, (state_reg != ST_UPDATE) || $onehot0(hit), "double hit")
    `FCM_ASSERT(a_used_bound, flows_used_reg <= W'(N), "flow count too large")
    `FCM_ASSERT(a_rem_bound, (state_reg != ST_EXPORT) || (rem_reg <= flows_used_reg), "overrun")
    `FCM_ASSERT_NEXT(a_append, append, flows_used_reg == $past(flows_used_reg) + W'(1), "lost")

endmodule

// ----- bench/flow_cache_meter_tb.sv -----
`timescale 1ns / 1ps

module flow_cache_meter_tb;

    // One parsed packet header as the bench sees it.
    typedef struct {
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [63:0] sh;
        logic [63:0] sl;
        logic [63:0] dh;
        logic [63:0] dl;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [15:0] plen;
        logic [31:0] now;
    } header_t;

    typedef struct {
        logic [335:0] data;
        logic [23:0]  user;
    } header_word_t;

    typedef struct {
        logic [479:0] data;
        logic [1:0]   kind;
        logic         lst;
    } record_t;

    localparam int FIELD_LO [10] = '{0, 64, 128, 192, 256, 272, 288, 352, 416, 448};
    localparam int FIELD_W  [10] = '{64, 64, 64, 64, 16, 16, 64, 64, 32, 32};

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [335:0] s_tdata;
    logic [23:0]  s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [479:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    header_word_t headers_pending [$];
    record_t      records_due [$];
    int           mismatches;
    bit           calm;

    // Shadow copy of the flow table and registers.
    fcm_pkg::entry_t table_mirror [fcm_pkg::FLOW_ENTRIES];
    int              mirror_used;
    logic [31:0]     mirror_last_export;
    logic [15:0]     mirror_interval;

    flow_cache_meter uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("flow_cache_meter_tb NOT OK");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    // Work out the records that one header causes, and update the mirror.
    task automatic predict_flows(input header_t h);
        fcm_pkg::key_t   k;
        record_t         r;
        int              n;
        int              hit;
        fcm_pkg::entry_t e;
        n = 0;
        if (h.now >= mirror_last_export && (h.now - mirror_last_export) >= mirror_interval)
        begin
            for (int i = 0; i < mirror_used; i++)
            begin
                e = table_mirror[i];
                if (e.packets != 64'd0)
                begin
                    r.kind = {e.key.ipv6, e.key.tcp};
                    r.data = {e.last, e.first, e.bytes, e.packets, e.key.dport,
                              e.key.sport, e.key.dst_low, e.key.dst_high,
                              e.key.src_low, e.key.src_high};
                    r.lst = 1'b0;
                    records_due.push_back(r);
                    n++;
                end
            end
            if (n > 0)
                records_due[records_due.size() - 1].lst = 1'b1;
            mirror_used = 0;
            mirror_last_export = h.now;
        end
        if (h.etype != fcm_pkg::ETH_IPV4 && h.etype != fcm_pkg::ETH_IPV6)
            return;
        if (h.proto != fcm_pkg::PROTO_TCP && h.proto != fcm_pkg::PROTO_UDP)
            return;
        k.ipv6 = (h.etype == fcm_pkg::ETH_IPV6);
        k.tcp = (h.proto == fcm_pkg::PROTO_TCP);
        k.src_high = k.ipv6 ? h.sh : 64'd0;
        k.dst_high = k.ipv6 ? h.dh : 64'd0;
        k.src_low = k.ipv6 ? h.sl : {32'd0, h.sl[31:0]};
        k.dst_low = k.ipv6 ? h.dl : {32'd0, h.dl[31:0]};
        k.sport = h.sp;
        k.dport = h.dp;
        hit = -1;
        for (int i = 0; i < mirror_used; i++)
            if (hit < 0 && table_mirror[i].key == k)
                hit = i;
        if (hit < 0)
        begin
            if (mirror_used >= fcm_pkg::FLOW_ENTRIES)
                return;
            hit = mirror_used;
            mirror_used++;
            table_mirror[hit] = '0;
            table_mirror[hit].key = k;
        end
        table_mirror[hit].packets += 64'd1;
        table_mirror[hit].bytes += {48'd0, h.plen};
        if (table_mirror[hit].packets == 64'd1)
            table_mirror[hit].first = h.now;
        table_mirror[hit].last = h.now;
    endtask

    task automatic send_header(input header_t h);
        header_word_t w;
        w.data = {h.now, h.plen, h.dp, h.sp, h.dl, h.dh, h.sl, h.sh};
        w.user = {h.proto, h.etype};
        predict_flows(h);
        headers_pending.push_back(w);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fcm_pkg::REG_INTERVAL)
            mirror_interval = val[15:0];
        else if (idx == fcm_pkg::REG_START_TIME)
            mirror_last_export = val;
    endtask

    // Wait until every header is taken and every record has come out.
    task automatic drain;
        while (headers_pending.size() != 0 || s_tvalid || records_due.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic header_t rand_header(input logic [15:0] et, input logic [7:0] pr,
                                            input logic [31:0] t);
        header_t h;
        h.etype = et;
        h.proto = pr;
        h.sh = {$urandom, $urandom};
        h.sl = {$urandom, $urandom};
        h.dh = {$urandom, $urandom};
        h.dl = {$urandom, $urandom};
        h.sp = 16'($urandom);
        h.dp = 16'($urandom);
        h.plen = 16'($urandom);
        h.now = t;
        return h;
    endfunction

    // Driver: offer the next header word, idling at random unless calm.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (headers_pending.size() != 0 && (calm || $urandom_range(99) >= 34))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= headers_pending[0].data;
                s_tuser <= headers_pending[0].user;
                headers_pending.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: take each record word and check it against the oldest one due.
    always @(posedge clk)
    begin : monitor
        record_t      r;
        logic [479:0] m;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (records_due.size() == 0)
                begin
                    note_mismatch("record with none due", 64'd0, m_tdata[63:0]);
                end
                else
                begin
                    r = records_due.pop_front();
                    if (m_tuser != r.kind)
                        note_mismatch("flow_kind", 64'(r.kind), 64'(m_tuser));
                    if (m_tlast != r.lst)
                        note_mismatch("last", 64'(r.lst), 64'(m_tlast));
                    for (int f = 0; f < 10; f++)
                    begin
                        m = (480'd1 << FIELD_W[f]) - 480'd1;
                        if (((m_tdata >> FIELD_LO[f]) & m) != ((r.data >> FIELD_LO[f]) & m))
                            note_mismatch($sformatf("data field %0d", f),
                                          64'((r.data >> FIELD_LO[f]) & m),
                                          64'((m_tdata >> FIELD_LO[f]) & m));
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 34);
        end
        else
        begin
            m_tready <= 1'b0;
        end
    end

    initial
    begin
        header_t     h;
        header_t     pool [8];
        logic [31:0] t;
        int          pick;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = fcm_pkg::REG_INTERVAL;
        cfg_data = '0;
        mismatches = 0;
        calm = 1'b0;
        mirror_used = 0;
        mirror_last_export = 32'd0;
        mirror_interval = fcm_pkg::DEFAULT_INTERVAL;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part under the reset settings.
        h = rand_header(fcm_pkg::ETH_IPV4, fcm_pkg::PROTO_TCP, 32'd0);
        send_header(h);
        h.etype = fcm_pkg::ETH_IPV6;
        h.now = 32'd1;
        send_header(h);
        h.etype = fcm_pkg::ETH_IPV4;
        h.proto = fcm_pkg::PROTO_UDP;
        h.now = 32'd2;
        send_header(h);
        h.proto = fcm_pkg::PROTO_TCP;
        h.sh = ~h.sh;
        h.sl[63:32] = ~h.sl[63:32];
        h.plen = 16'hFFFF;
        h.now = 32'd5;
        send_header(h);
        send_header(rand_header(16'h1234, fcm_pkg::PROTO_TCP, 32'd6));
        send_header(rand_header(fcm_pkg::ETH_IPV4, 8'd1, 32'd7));
        h = rand_header(fcm_pkg::ETH_IPV6, fcm_pkg::PROTO_UDP, 32'd10);
        h.sh = '1; h.sl = '1; h.dh = '1; h.dl = '1;
        h.sp = '1; h.dp = '1; h.plen = '1;
        send_header(h);
        send_header(rand_header(fcm_pkg::ETH_IPV6, fcm_pkg::PROTO_TCP, 32'd40));
        send_header(rand_header(fcm_pkg::ETH_IPV4, fcm_pkg::PROTO_UDP, 32'd39));
        h = rand_header(fcm_pkg::ETH_IPV4, fcm_pkg::PROTO_TCP, 32'd70);
        h.sh = '0; h.sl = '0; h.dh = '0; h.dl = '0;
        h.sp = '0; h.dp = '0; h.plen = '0;
        send_header(h);
        send_header(h);
        drain();

        // Zero interval: every header exports; an earlier time does not.
        write_reg(fcm_pkg::REG_INTERVAL, 32'd0);
        write_reg(fcm_pkg::REG_START_TIME, 32'd100);
        write_reg(2'd2, $urandom);
        write_reg(2'd3, $urandom);
        send_header(rand_header(fcm_pkg::ETH_IPV4, fcm_pkg::PROTO_TCP, 32'd50));
        send_header(rand_header(fcm_pkg::ETH_IPV6, fcm_pkg::PROTO_UDP, 32'd100));
        send_header(rand_header(16'hFFFF, 8'hFF, 32'd101));
        send_header(rand_header(16'h0000, 8'h00, 32'd102));
        drain();
        write_reg(fcm_pkg::REG_START_TIME, 32'hFFFF_FFFF);
        send_header(rand_header(fcm_pkg::ETH_IPV4, fcm_pkg::PROTO_UDP, 32'hFFFF_FFFE));
        send_header(rand_header(fcm_pkg::ETH_IPV6, fcm_pkg::PROTO_TCP, 32'hFFFF_FFFF));
        send_header(rand_header(fcm_pkg::ETH_IPV4, fcm_pkg::PROTO_TCP, 32'hFFFF_FFFF));
        drain();

        // Widest interval: overfill the table, then export it whole.
        write_reg(fcm_pkg::REG_INTERVAL, 32'hFFFF);
        write_reg(fcm_pkg::REG_START_TIME, 32'd0);
        for (int i = 0; i < 36; i++)
            send_header(rand_header(fcm_pkg::ETH_IPV4, fcm_pkg::PROTO_UDP, 32'(i + 1)));
        send_header(rand_header(fcm_pkg::ETH_IPV4, fcm_pkg::PROTO_UDP, 32'd65534));
        send_header(rand_header(fcm_pkg::ETH_IPV6, fcm_pkg::PROTO_TCP, 32'd65535));
        drain();

        // Random part: a small pool of flows with some noise.
        for (int ph = 0; ph < 2; ph++)
        begin
            calm = (ph == 0);
            t = $urandom_range(32'hFFF0_0000);
            write_reg(fcm_pkg::REG_INTERVAL, $urandom_range(3, 20));
            write_reg(fcm_pkg::REG_START_TIME, t);
            for (int i = 0; i < 8; i++)
                pool[i] = rand_header($urandom_range(1) ? fcm_pkg::ETH_IPV6 : fcm_pkg::ETH_IPV4,
                                      $urandom_range(1) ? fcm_pkg::PROTO_TCP
                                                        : fcm_pkg::PROTO_UDP, t);
            for (int n = 0; n < 60; n++)
            begin
                if ($urandom_range(99) < 5)
                    t = t - $urandom_range(1, 4);
                else
                    t = t + $urandom_range(0, 3);
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    h = pool[$urandom_range(7)];
                    h.plen = 16'($urandom);
                    h.now = t;
                end
                else if (pick < 85)
                begin
                    h = rand_header($urandom_range(1) ? fcm_pkg::ETH_IPV6 : fcm_pkg::ETH_IPV4,
                                    $urandom_range(1) ? fcm_pkg::PROTO_TCP
                                                      : fcm_pkg::PROTO_UDP, t);
                end
                else
                begin
                    h = rand_header(16'($urandom), 8'($urandom), t);
                end
                send_header(h);
            end
            drain();
        end

        if (mismatches == 0)
            $display("flow_cache_meter_tb OK");
        else
            $display("flow_cache_meter_tb NOT OK");
        $finish;
    end

endmodule
